// ===== design/lfid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lowest free ID allocator package
// Shared sizes and constants for the identifier range and the bitmap memory.
// ----------------------------------------------------------------------------
package lfid_pkg;

	// Identifier range handed out by the allocator.
	localparam int unsigned BASE_ID   = 300;
	localparam int unsigned NUM_IDS   = 4096;
	localparam int unsigned MAP_DEPTH = 4096;
	localparam int unsigned ID_W      = 13;

	// The bitmap is kept as rows of 64 in-use bits.
	localparam int unsigned ROW_W     = 64;
	localparam int unsigned BIT_AW    = 6;
	localparam int unsigned ROW_N     = MAP_DEPTH / ROW_W;
	localparam int unsigned ROW_AW    = 6;
	localparam int unsigned OFF_W     = ROW_AW + BIT_AW;

	// Rows that actually hold identifiers, and the unused tail of the last one.
	localparam int unsigned ROWS_USED = (NUM_IDS + ROW_W - 1) / ROW_W;
	localparam int unsigned ROW_LAST  = ROWS_USED - 1;
	localparam int unsigned LAST_BITS = NUM_IDS - ROW_LAST * ROW_W;
	localparam logic [ROW_W-1:0] PAD_MASK = (LAST_BITS == ROW_W) ? '0 :
		~((64'd1 << LAST_BITS) - 64'd1);

	// Command codes.
	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

endpackage

// ===== design/lowest_free_id_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lowest free ID allocator
// Hands out the lowest free identifier of a range and takes identifiers back.
// ----------------------------------------------------------------------------
// The allocator keeps one in-use bit per identifier in BASE_ID ..
// BASE_ID + NUM_IDS - 1, stored as 64-bit rows in a single-port-read,
// single-port-write synchronous memory with a registered read.
// Reset marks every identifier free at once through a per-row valid flag, so
// no clearing pass is needed and the block takes beats right after reset.
// An allocate beat scans the rows from the bottom, one row per cycle. A
// successful one reads 1 to 64 rows, then passes through the pick and emit
// steps, and the next beat can be taken once the emit step has handed its
// result to the output register. The row scan is what sets how long the
// block stays busy. A failed allocation reads all 64 used rows, skips the
// pick step, and offers granted_id 0 with alloc_failed set. A release beat
// produces no result: an in-range release reads its row, then writes it
// back; an out-of-range one is dropped as it is taken. Items are processed
// one at a time; a finished result waits in the output register and the
// next beat is taken while it waits.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator
	import lfid_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  logic            command,
	input  logic [ID_W-1:0] release_id,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output logic [ID_W-1:0] granted_id,
	output logic            alloc_failed
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_REL_RD,
		S_SCAN,
		S_PICK,
		S_EMIT
	} state_t;

	// Bitmap memory and its per-row valid flags. A row never written reads as
	// all free.
	logic [ROW_W-1:0]  map_mem [ROW_N];
	logic [ROW_W-1:0]  rdata_q;
	logic [ROW_N-1:0]  row_valid_q;

	state_t            state_q;
	logic [ROW_AW-1:0] row_q;
	logic [BIT_AW-1:0] bit_q;
	logic [ROW_W-1:0]  word_s1;
	logic [ID_W-1:0]   res_id_q;
	logic              res_fail_q;
	logic              rsp_valid_q;
	logic [ID_W-1:0]   granted_id_q;
	logic              alloc_failed_q;

	logic              req_fire;
	logic              slot_free;
	logic [ID_W-1:0]   rel_off;
	logic              rel_in_range;
	logic [ROW_AW-1:0] rd_addr;
	logic              wr_en;
	logic [ROW_W-1:0]  wr_data;
	logic [ROW_W-1:0]  cur_word;
	logic [ROW_W-1:0]  scan_word;
	logic [ROW_W-1:0]  pick_word;
	logic [BIT_AW-1:0] pick_bit;

	// Lowest clear bit of a row.
	function automatic logic [BIT_AW-1:0] lowest_zero(input logic [ROW_W-1:0] w);
		logic [BIT_AW-1:0] idx;
		idx = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (!w[i]) begin
				idx = BIT_AW'(i);
			end
		end
		return idx;
	endfunction

	assign req_stall = (state_q != S_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign slot_free = !rsp_valid_q || !rsp_stall;

	// A release is honored only for identifiers inside the managed range.
	assign rel_off      = release_id - ID_W'(BASE_ID);
	assign rel_in_range = (release_id >= ID_W'(BASE_ID)) && (rel_off < ID_W'(NUM_IDS));

	// Read data belongs to row_q in the cycle after the read was issued.
	assign cur_word  = row_valid_q[row_q] ? rdata_q : '0;
	assign scan_word = (row_q == ROW_AW'(ROW_LAST)) ? (cur_word | PAD_MASK) : cur_word;
	assign pick_word = (row_q == ROW_AW'(ROW_LAST)) ? (word_s1 | PAD_MASK) : word_s1;
	assign pick_bit  = lowest_zero(pick_word);

	always_comb begin
		rd_addr = row_q;
		wr_en   = 1'b0;
		wr_data = word_s1;
		case (state_q)
			S_IDLE: begin
				rd_addr = (command == CMD_RELEASE) ? rel_off[OFF_W-1:BIT_AW] : '0;
			end
			S_REL_RD: begin
				wr_en   = 1'b1;
				wr_data = cur_word & ~(64'd1 << bit_q);
			end
			S_SCAN: begin
				rd_addr = row_q + ROW_AW'(1);
			end
			S_PICK: begin
				wr_en   = 1'b1;
				wr_data = word_s1 | (64'd1 << pick_bit);
			end
			default: begin
				rd_addr = row_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rdata_q <= map_mem[rd_addr];
		if (wr_en) begin
			map_mem[row_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			row_q          <= '0;
			bit_q          <= '0;
			word_s1        <= '0;
			res_id_q       <= '0;
			res_fail_q     <= 1'b0;
			row_valid_q    <= '0;
			rsp_valid_q    <= 1'b0;
			granted_id_q   <= '0;
			alloc_failed_q <= 1'b0;
		end else begin
			// A new result beat takes the output register in the same cycle the
			// old one leaves it.
			if (state_q == S_EMIT && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (wr_en) begin
				row_valid_q[row_q] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (command == CMD_ALLOC) begin
							row_q   <= '0;
							state_q <= S_SCAN;
						end else if (rel_in_range) begin
							row_q   <= rel_off[OFF_W-1:BIT_AW];
							bit_q   <= rel_off[BIT_AW-1:0];
							state_q <= S_REL_RD;
						end
					end
				end
				S_REL_RD: begin
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (scan_word != '1) begin
						word_s1 <= cur_word;
						state_q <= S_PICK;
					end else if (row_q == ROW_AW'(ROW_LAST)) begin
						res_id_q   <= '0;
						res_fail_q <= 1'b1;
						state_q    <= S_EMIT;
					end else begin
						row_q <= row_q + ROW_AW'(1);
					end
				end
				S_PICK: begin
					res_id_q   <= ID_W'(BASE_ID) + ID_W'({row_q, pick_bit});
					res_fail_q <= 1'b0;
					state_q    <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						granted_id_q   <= res_id_q;
						alloc_failed_q <= res_fail_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign granted_id   = granted_id_q;
	assign alloc_failed = alloc_failed_q;

	// A failed allocation always reports identifier zero.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && alloc_failed |-> granted_id == '0)
		else $error("failed allocation with nonzero identifier");

	// A granted identifier lies inside the managed range.
	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !alloc_failed |->
			(granted_id >= ID_W'(BASE_ID)) && (granted_id < ID_W'(BASE_ID + NUM_IDS)))
		else $error("granted identifier out of range");

	// A new result beat appears only out of the emit step.
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == S_EMIT))
		else $error("result beat without an allocation");

	// The bitmap is never written beyond the rows in use.
	a_wr_row: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> row_q <= ROW_AW'(ROW_LAST))
		else $error("bitmap write outside the used rows");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lowest free ID allocator testbench
// Drives allocate and release beats into the allocator and checks every grant
// beat against a bitmap kept inside the bench, with random idling on both
// sides, one long output hold-off, and a phase that fills the whole range.
// ----------------------------------------------------------------------------
module tb_top;
	import lfid_pkg::*;

	// Longest stretch without any beat on either channel before giving up.
	// A full scan and the long hold-off are both far shorter than this, so it
	// leaves a wide margin.
	localparam int WATCHDOG_LIMIT  = 3000;
	// Cycles the receiver holds off once, while the sender keeps offering.
	localparam int PRESSURE_CYCLES = 250;
	// Cycles allowed after the last grant for a trailing release write-back
	// and for any stray beat to show up.
	localparam int DRAIN_CYCLES    = 100;

	// One request beat as it is queued for the driver.
	typedef struct packed {
		logic            cmd;
		logic [ID_W-1:0] rid;
	} id_request_t;

	// One grant beat as the bitmap says it must look.
	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            failed;
	} grant_t;

	logic            clk          = 1'b0;
	logic            arst_n       = 1'b0;
	logic            req_valid    = 1'b0;
	logic            req_stall;
	logic            command      = CMD_ALLOC;
	logic [ID_W-1:0] release_id   = '0;
	logic            rsp_valid;
	logic            rsp_stall    = 1'b0;
	logic [ID_W-1:0] granted_id;
	logic            alloc_failed;

	// Request beats waiting to be driven, and grant beats waiting to arrive.
	id_request_t     pending_requests[$];
	grant_t          expected_grants[$];

	// The bench's own copy of the in-use bitmap, one bit per identifier offset.
	bit [NUM_IDS-1:0] id_in_use = '0;

	// Acceptance seen at the last rising edge, read by the falling-edge drivers.
	logic            req_fire     = 1'b0;
	logic            rsp_fire     = 1'b0;

	int              req_beats    = 0;
	int              fail_count   = 0;
	int              idle_cycles  = 0;
	// Rough count of held identifiers, used only to aim releases at live IDs.
	int              est_held     = 0;
	bit              hold_rsp     = 1'b0;

	int              send_wait    = 0;
	int              send_quiet   = 0;
	int              recv_wait    = 0;
	int              recv_quiet   = 0;

	lowest_free_id_allocator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.command      (command),
		.release_id   (release_id),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.granted_id   (granted_id),
		.alloc_failed (alloc_failed)
	);

	always #2 clk = ~clk;

	// Idle cycles before the next beat on one side: mostly 0 to 4, but now and
	// then a stretch of beats with no idling at all.
	function automatic int draw_wait(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) begin
			quiet = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 4);
	endfunction

	task automatic queue_request(input logic cmd, input int unsigned rid);
		id_request_t r;
		r.cmd = cmd;
		r.rid = rid[ID_W-1:0];
		pending_requests.push_back(r);
		if (cmd == CMD_ALLOC) begin
			if (est_held < NUM_IDS)
				est_held++;
		end else if (rid >= BASE_ID && rid < BASE_ID + est_held) begin
			est_held--;
		end
	endtask

	// Random mix of allocations and releases. Releases are mostly aimed at the
	// identifiers that are probably held, the rest hit the range edges or any
	// 13-bit value at all.
	task automatic queue_mix(input int count, input int alloc_pct);
		int          pick;
		int unsigned rid;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < alloc_pct) begin
				queue_request(CMD_ALLOC, $urandom_range(0, 8191));
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 8) begin
					rid = $urandom_range(BASE_ID, BASE_ID + est_held + 8);
				end else if (pick == 8) begin
					rid = $urandom_range(0, 8191);
				end else begin
					case ($urandom_range(0, 3))
						0: begin
							rid = BASE_ID - 1;
						end
						1: begin
							rid = BASE_ID;
						end
						2: begin
							rid = BASE_ID + NUM_IDS - 1;
						end
						default: begin
							rid = BASE_ID + NUM_IDS;
						end
					endcase
				end
				queue_request(CMD_RELEASE, rid);
			end
		end
	endtask

	// Request driver. A beat stays on the bus until it is taken; after that the
	// next one follows once the drawn number of idle cycles has passed.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_fire) begin
			if (req_valid)
				send_wait = draw_wait(send_quiet);
			if (send_wait == 0 && pending_requests.size() != 0) begin
				req_valid  <= 1'b1;
				command    <= pending_requests[0].cmd;
				release_id <= pending_requests[0].rid;
				pending_requests.pop_front();
			end else begin
				req_valid <= 1'b0;
				if (send_wait > 0)
					send_wait--;
			end
		end
	end

	// Grant receiver. Each grant beat is held off for a drawn number of cycles
	// while it is offered; the long hold-off overrides that.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_fire)
				recv_wait = draw_wait(recv_quiet);
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
			end else if (rsp_valid && recv_wait > 0) begin
				rsp_stall <= 1'b1;
				recv_wait--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Monitor. At each rising edge an accepted request beat updates the bench
	// bitmap and, for an allocation, queues the grant it must produce; an
	// accepted grant beat is checked against the oldest queued grant.
	always @(posedge clk) begin : monitor
		int     free_off;
		grant_t want;
		req_fire <= arst_n && req_valid && !req_stall;
		rsp_fire <= arst_n && rsp_valid && !rsp_stall;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				req_beats++;
				if (command == CMD_RELEASE) begin
					// Out-of-range releases and releases of free IDs change nothing.
					if (release_id >= BASE_ID && release_id < BASE_ID + NUM_IDS)
						id_in_use[release_id - BASE_ID] = 1'b0;
				end else begin
					free_off = -1;
					for (int k = 0; k < NUM_IDS && free_off < 0; k++)
						if (!id_in_use[k])
							free_off = k;
					if (free_off < 0) begin
						// Full map: a failure beat with a zero identifier.
						want.id     = '0;
						want.failed = 1'b1;
					end else begin
						id_in_use[free_off] = 1'b1;
						want.id     = ID_W'(BASE_ID + free_off);
						want.failed = 1'b0;
					end
					expected_grants.push_back(want);
				end
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_grants.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("grant beat with none pending: granted_id=%0d alloc_failed=%0b",
							granted_id, alloc_failed);
				end else begin
					want = expected_grants.pop_front();
					if (granted_id !== want.id || alloc_failed !== want.failed) begin
						fail_count++;
						if (fail_count <= 10)
							$display("grant mismatch: expected id=%0d failed=%0b, got id=%0d failed=%0b",
								want.id, want.failed, granted_id, alloc_failed);
					end
				end
			end
			// Watchdog: the run is stuck if no beat moves for too long.
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Long hold-off on the grant side during the random part, so that a grant
	// waits in the output register, the next allocation completes behind it,
	// and the block has to stall its request side.
	initial begin
		wait (arst_n);
		wait (req_beats >= 150);
		@(posedge clk);
		hold_rsp = 1'b1;
		repeat (PRESSURE_CYCLES) @(posedge clk);
		hold_rsp = 1'b0;
	end

	initial begin
		// Directed part: first grants, reuse of a freed ID, repeated release of
		// a free ID, releases just outside both ends of the range and at the
		// extremes of the field, and allocations carrying odd release_id values.
		queue_request(CMD_ALLOC, 0);
		queue_request(CMD_ALLOC, 8191);
		queue_request(CMD_ALLOC, 0);
		queue_request(CMD_RELEASE, BASE_ID + 1);
		queue_request(CMD_ALLOC, 0);
		queue_request(CMD_RELEASE, BASE_ID + 1);
		queue_request(CMD_RELEASE, BASE_ID + 1);
		queue_request(CMD_RELEASE, BASE_ID - 1);
		queue_request(CMD_RELEASE, BASE_ID + NUM_IDS);
		queue_request(CMD_RELEASE, 0);
		queue_request(CMD_RELEASE, 8191);
		queue_request(CMD_RELEASE, BASE_ID + NUM_IDS - 1);
		queue_request(CMD_RELEASE, BASE_ID);
		queue_request(CMD_ALLOC, 8191);
		queue_request(CMD_ALLOC, 0);
		queue_request(CMD_RELEASE, BASE_ID);
		queue_request(CMD_RELEASE, BASE_ID + 2);
		queue_request(CMD_ALLOC, BASE_ID);
		queue_request(CMD_ALLOC, 5000);

		// Random part over a sparsely used map.
		queue_mix(1200, 55);

		// Fill the whole range from whatever state it is in, then ask for more
		// so that allocations fail on a full map.
		repeat (NUM_IDS) queue_request(CMD_ALLOC, $urandom_range(0, 8191));
		repeat (3) queue_request(CMD_ALLOC, $urandom_range(0, 8191));
		queue_request(CMD_RELEASE, BASE_ID + NUM_IDS - 1);
		queue_request(CMD_ALLOC, 0);
		queue_request(CMD_ALLOC, 0);
		queue_request(CMD_RELEASE, BASE_ID + NUM_IDS);
		queue_request(CMD_ALLOC, 0);
		queue_request(CMD_RELEASE, BASE_ID);
		queue_request(CMD_RELEASE, BASE_ID + 2000);
		queue_request(CMD_ALLOC, 8191);
		queue_request(CMD_ALLOC, 8191);
		queue_request(CMD_ALLOC, 8191);

		// Random part around a nearly full map, where holes sit in high rows
		// and failures come and go.
		queue_mix(300, 50);

		repeat (7) @(posedge clk);
		#1 arst_n = 1'b1;

		while (pending_requests.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_grants.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && expected_grants.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/lfid_pkg.sv
design/lowest_free_id_allocator.sv
bench/tb_top.sv
